>>> rtl/vrt_pkg.sv
// Shared types and constants for the VLAN registration tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package vrt_pkg;

  // MRP event codes
  localparam logic [2:0] EV_NEW      = 3'd0;
  localparam logic [2:0] EV_JOININ   = 3'd1;
  localparam logic [2:0] EV_IN       = 3'd2;
  localparam logic [2:0] EV_JOINMT   = 3'd3;
  localparam logic [2:0] EV_MT       = 3'd4;
  localparam logic [2:0] EV_LV       = 3'd5;
  localparam logic [2:0] EV_LEAVEALL = 3'd6;

  // VLAN states
  localparam logic [1:0] ST_UNKNOWN    = 2'd0;
  localparam logic [1:0] ST_REGISTERED = 2'd1;
  localparam logic [1:0] ST_LEAVING    = 2'd2;
  localparam logic [1:0] ST_WITHDRAWN  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_TRANS      = 2'd0;
  localparam logic [1:0] KIND_TABLE_FULL = 2'd1;
  localparam logic [1:0] KIND_MEMB_FULL  = 2'd2;

  localparam int DEF_MAX_VLANS   = 32;
  localparam int DEF_MAX_MEMBERS = 8;
  localparam int RESULT_CAP      = 32;
  localparam int RCW             = $clog2(RESULT_CAP + 1);

  typedef struct packed {
    logic [2:0]  event_code;
    logic [11:0] vlan_id;
    logic [47:0] sender_mac;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] result_vid;
    logic [1:0]  from_state;
    logic [1:0]  to_state;
    logic [2:0]  cause_event;
    logic [47:0] cause_mac;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic leave_all;
    logic join_ev;
    logic leave_ev;
  } ev_class_t;

  typedef struct packed {
    ev_class_t cls;
    in_item_t  item;
  } q_item_t;

endpackage

>>> rtl/vrt_front.sv
// Front end: accepts requests, classifies the event code, queues them.
// Depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_front
  import vrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_data,
  input  logic     q_pop
);

  q_item_t    q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] q_cnt_r;
  q_item_t    cls_item;
  logic       push;

  // classify the event
  always_comb begin
    cls_item.item          = in_data;
    cls_item.cls.leave_all = (in_data.event_code == EV_LEAVEALL);
    cls_item.cls.join_ev   = (in_data.event_code == EV_NEW) ||
                             (in_data.event_code == EV_JOININ) ||
                             (in_data.event_code == EV_JOINMT);
    cls_item.cls.leave_ev  = (in_data.event_code == EV_LV);
  end

  assign in_stall = (q_cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_data   = q_mem_r[rd_ptr_r];

  // store queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/vrt_back.sv
// Back end: VLAN table, member store, event sequencer and result register.
// Depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_back
  import vrt_pkg::*;
#(
  parameter int MAX_VLANS   = DEF_MAX_VLANS,
  parameter int MAX_MEMBERS = DEF_MAX_MEMBERS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int VW  = (MAX_VLANS > 1) ? $clog2(MAX_VLANS) : 1;
  localparam int CW  = $clog2(MAX_VLANS + 1);
  localparam int MW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int MCW = $clog2(MAX_MEMBERS + 1);
  localparam int MD  = MAX_VLANS * MAX_MEMBERS;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int RW  = 14 + MAX_MEMBERS;
  localparam logic [AW-1:0] MM_A = AW'(MAX_MEMBERS);

  typedef enum logic [4:0] {
    S_IDLE, S_LK_RD, S_LK_EV, S_CREATE, S_DISP, S_MB_RD, S_MB_EV, S_JN_END,
    S_MFULL, S_JN_REG, S_LV_END, S_EMIT_T, S_TFULL, S_LA_RD, S_LA_EV,
    S_LA_END, S_LA_EMIT, S_LA_FLUSH
  } state_t;

  // memories
  logic [RW-1:0] ent_mem [MAX_VLANS];
  logic [47:0]   mac_mem [MD];
  logic [RW-1:0] ent_rd_r;
  logic [47:0]   mac_rd_r;

  state_t                 st_r;
  ev_class_t              cls_r;
  logic [2:0]             ev_r;
  logic [11:0]            vid_r;
  logic [47:0]            mac_r;
  logic [CW-1:0]          idx_r;
  logic [CW-1:0]          ent_cnt_r;
  logic [VW-1:0]          slot_r;
  logic [AW-1:0]          base_r;
  logic [1:0]             cur_state_r;
  logic [MAX_MEMBERS-1:0] cur_mask_r;
  logic [MCW-1:0]         m_r;
  logic                   found_r;
  logic [1:0]             tgt_r;
  logic                   best_v_r;
  logic [11:0]            best_vid_r;
  logic [VW-1:0]          best_idx_r;
  logic [MAX_MEMBERS-1:0] best_mask_r;
  logic                   pend_v_r;
  logic [11:0]            pend_vid_r;
  logic [RCW-1:0]         la_cnt_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic                   ent_we, ent_re, mac_we, mac_re;
  logic [VW-1:0]          ent_wa;
  logic [RW-1:0]          ent_wd;
  logic [AW-1:0]          mac_a;
  logic [11:0]            rd_vid;
  logic [1:0]             rd_state;
  logic [MAX_MEMBERS-1:0] rd_mask;
  logic [MW-1:0]          freem;
  logic                   can_emit, emit, withdraw;
  out_item_t              res;

  assign rd_vid   = ent_rd_r[RW-1 -: 12];
  assign rd_state = ent_rd_r[MAX_MEMBERS+1 -: 2];
  assign rd_mask  = ent_rd_r[MAX_MEMBERS-1:0];
  assign can_emit = !out_valid_r || !out_stall;
  assign q_pop    = (st_r == S_IDLE) && q_valid;
  assign withdraw = (cur_mask_r == '0) && (cur_state_r != ST_WITHDRAWN);
  assign mac_a    = base_r + AW'(m_r);

  // pick lowest free member slot
  always_comb begin
    freem = '0;
    for (int k = MAX_MEMBERS - 1; k >= 0; k--) begin
      if (!cur_mask_r[k]) freem = MW'(k);
    end
  end

  // memory port controls
  always_comb begin
    ent_we = 1'b0;
    ent_wa = slot_r;
    ent_wd = {vid_r, cur_state_r, cur_mask_r};
    ent_re = 1'b0;
    mac_we = 1'b0;
    mac_re = 1'b0;
    unique case (st_r)
      S_LK_RD, S_LA_RD: ent_re = (idx_r != ent_cnt_r);
      S_CREATE: begin
        ent_we = 1'b1;
        ent_wa = ent_cnt_r[VW-1:0];
        ent_wd = {vid_r, ST_UNKNOWN, {MAX_MEMBERS{1'b0}}};
      end
      S_MB_RD:  mac_re = (m_r != MCW'(MAX_MEMBERS));
      S_JN_END: mac_we = !found_r && !(&cur_mask_r);
      S_JN_REG: begin
        ent_we = 1'b1;
        ent_wd = {vid_r, ST_REGISTERED, cur_mask_r};
      end
      S_LV_END: begin
        ent_we = 1'b1;
        ent_wd = {vid_r, withdraw ? ST_WITHDRAWN : cur_state_r, cur_mask_r};
      end
      S_LA_END: begin
        ent_we = best_v_r;
        ent_wa = best_idx_r;
        ent_wd = {best_vid_r, ST_LEAVING, best_mask_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_r <= ent_mem[idx_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mac_we) mac_mem[base_r + AW'(freem)] <= mac_r;
    if (mac_re) mac_rd_r <= mac_mem[mac_a];
  end

  // build the result for the emitting states
  always_comb begin
    emit            = 1'b0;
    res.kind        = KIND_TRANS;
    res.result_vid  = vid_r;
    res.from_state  = cur_state_r;
    res.to_state    = tgt_r;
    res.cause_event = ev_r;
    res.cause_mac   = mac_r;
    res.last        = 1'b1;
    unique case (st_r)
      S_MFULL: begin
        emit         = can_emit;
        res.kind     = KIND_MEMB_FULL;
        res.to_state = cur_state_r;
        res.last     = (cur_state_r == ST_REGISTERED);
      end
      S_EMIT_T: emit = can_emit;
      S_TFULL: begin
        emit           = can_emit;
        res.kind       = KIND_TABLE_FULL;
        res.from_state = ST_UNKNOWN;
        res.to_state   = ST_UNKNOWN;
      end
      S_LA_EMIT, S_LA_FLUSH: begin
        emit           = can_emit;
        res.result_vid = pend_vid_r;
        res.from_state = ST_REGISTERED;
        res.to_state   = ST_LEAVING;
        res.last       = (st_r == S_LA_FLUSH);
      end
      default: ;
    endcase
  end

  // hold result register
  always_ff @(posedge clk) begin
    if (emit) out_data_r <= res;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ent_cnt_r   <= '0;
      la_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            ev_r     <= q_data.item.event_code;
            vid_r    <= q_data.item.vlan_id;
            mac_r    <= q_data.item.sender_mac;
            cls_r    <= q_data.cls;
            idx_r    <= '0;
            best_v_r <= 1'b0;
            pend_v_r <= 1'b0;
            la_cnt_r <= '0;
            st_r     <= q_data.cls.leave_all ? S_LA_RD : S_LK_RD;
          end
        end
        S_LK_RD: begin
          if (idx_r != ent_cnt_r) st_r <= S_LK_EV;
          else if (ent_cnt_r == CW'(MAX_VLANS)) st_r <= S_TFULL;
          else st_r <= S_CREATE;
        end
        S_LK_EV: begin
          if (rd_vid == vid_r) begin
            slot_r      <= idx_r[VW-1:0];
            base_r      <= AW'(idx_r[VW-1:0]) * MM_A;
            cur_state_r <= rd_state;
            cur_mask_r  <= rd_mask;
            st_r        <= S_DISP;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_LK_RD;
          end
        end
        S_CREATE: begin
          slot_r      <= ent_cnt_r[VW-1:0];
          base_r      <= AW'(ent_cnt_r[VW-1:0]) * MM_A;
          cur_state_r <= ST_UNKNOWN;
          cur_mask_r  <= '0;
          ent_cnt_r   <= ent_cnt_r + 1'b1;
          st_r        <= S_DISP;
        end
        S_DISP: begin
          m_r     <= '0;
          found_r <= 1'b0;
          st_r    <= (cls_r.join_ev || cls_r.leave_ev) ? S_MB_RD : S_IDLE;
        end
        S_MB_RD: begin
          if (m_r != MCW'(MAX_MEMBERS)) st_r <= S_MB_EV;
          else st_r <= cls_r.leave_ev ? S_LV_END : S_JN_END;
        end
        S_MB_EV: begin
          if (cur_mask_r[m_r[MW-1:0]] && (mac_rd_r == mac_r)) begin
            if (cls_r.leave_ev) cur_mask_r[m_r[MW-1:0]] <= 1'b0;
            else found_r <= 1'b1;
          end
          m_r  <= m_r + 1'b1;
          st_r <= S_MB_RD;
        end
        S_JN_END: begin
          if (!found_r && !(&cur_mask_r)) begin
            cur_mask_r[freem] <= 1'b1;
            st_r <= S_JN_REG;
          end else if (!found_r) begin
            st_r <= S_MFULL;
          end else begin
            st_r <= S_JN_REG;
          end
        end
        S_MFULL: if (can_emit) st_r <= S_JN_REG;
        S_JN_REG: begin
          tgt_r <= ST_REGISTERED;
          st_r  <= (cur_state_r != ST_REGISTERED) ? S_EMIT_T : S_IDLE;
        end
        S_LV_END: begin
          tgt_r <= ST_WITHDRAWN;
          st_r  <= withdraw ? S_EMIT_T : S_IDLE;
        end
        S_EMIT_T, S_TFULL, S_LA_FLUSH: if (can_emit) st_r <= S_IDLE;
        S_LA_RD: st_r <= (idx_r != ent_cnt_r) ? S_LA_EV : S_LA_END;
        S_LA_EV: begin
          if (rd_state == ST_REGISTERED && (!best_v_r || rd_vid < best_vid_r)) begin
            best_v_r    <= 1'b1;
            best_vid_r  <= rd_vid;
            best_idx_r  <= idx_r[VW-1:0];
            best_mask_r <= rd_mask;
          end
          idx_r <= idx_r + 1'b1;
          st_r  <= S_LA_RD;
        end
        S_LA_END: begin
          if (!best_v_r) begin
            st_r <= pend_v_r ? S_LA_FLUSH : S_IDLE;
          end else if (pend_v_r && la_cnt_r < RCW'(RESULT_CAP)) begin
            st_r <= S_LA_EMIT;
          end else begin
            if (!pend_v_r) begin
              pend_v_r   <= 1'b1;
              pend_vid_r <= best_vid_r;
              la_cnt_r   <= RCW'(1);
            end
            idx_r    <= '0;
            best_v_r <= 1'b0;
            st_r     <= S_LA_RD;
          end
        end
        S_LA_EMIT: begin
          if (can_emit) begin
            pend_vid_r <= best_vid_r;
            la_cnt_r   <= la_cnt_r + 1'b1;
            idx_r      <= '0;
            best_v_r   <= 1'b0;
            st_r       <= S_LA_RD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_cnt_r <= CW'(MAX_VLANS)) else $error("VLAN fill count overflow");
  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    la_cnt_r <= RCW'(RESULT_CAP)) else $error("LeaveAll result count over cap");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r) else $error("result not loaded");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r != S_IDLE)) else $error("popped request not taken");
  a_create_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CREATE) |-> (ent_cnt_r < CW'(MAX_VLANS)))
    else $error("entry created in full table");

endmodule

>>> rtl/vlan_registration_tracker.sv
// VLAN registration tracker (MVRP membership view), top level.
// Depends on vrt_pkg, vrt_front and vrt_back.
//
// Usage: each input request carries an MRP event code, a VID and a sender MAC
// on in_data, taken when in_valid is high and in_stall low. Results leave on
// out_data under out_valid/out_stall, one request giving zero or more results
// with last set on its final one.
// Operation: the sequencer handles one request at a time. A VID lookup reads
// the known table entries in turn until the VID matches; a join or leave then
// reads every member MAC slot of that VLAN in turn, and each result waits for
// the result register to have room. LeaveAll walks the whole table once per
// VLAN moved to leaving plus once more. Table entries and member MACs come
// from registered read ports.
// A two-entry queue sits in front, so up to two requests are taken while one
// is in work; the result register lets the next result be prepared while the
// current one waits.
// Reset clears the VLAN fill count; the tables need no clearing pass.
// While out_stall is high the result holds and the sequencer waits on it.
`timescale 1ns / 1ps
module vlan_registration_tracker
  import vrt_pkg::*;
#(
  parameter int MAX_VLANS   = DEF_MAX_VLANS,
  parameter int MAX_MEMBERS = DEF_MAX_MEMBERS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic    q_valid;
  q_item_t q_data;
  logic    q_pop;

  // accept and classify
  vrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // execute against the tables
  vrt_back #(
    .MAX_VLANS   (MAX_VLANS),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
